[src/gb3_pkg.sv]
// Shared types and constants of the 3x3 Gaussian blur block.
package gb3_pkg;

  localparam int CH_W       = 8;
  localparam int DATA_W     = 3 * CH_W;
  localparam int LL_W       = 11;
  localparam int LC_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BANKS      = 4;
  localparam int BANK_W     = 2;
  localparam int ROWS       = 3;

  localparam logic [LL_W-1:0] LL_RESET = 11'd640;
  localparam logic [LC_W-1:0] LC_RESET = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH = 2'd0,
    REG_LINE_COUNT  = 2'd1
  } cfg_reg_e;

  // Red sits in the lowest byte, matching the stream packing.
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef logic [BANK_W-1:0] bank_t;

endpackage

[src/gb3_ram.sv]
// Generic RAM with one write port and two registered read ports.
module gb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

[src/gaussian_blur_3x3_rgb.sv]
// Streaming 3x3 binomial blur of RGB pixels with clamp-to-edge borders.
//
//  Channel   Dir   Handshake               Payload
//  s_axis    in    tvalid/tready           tdata: red, green, blue; tuser: flush tick
//  m_axis    out   tvalid/tready           tdata: red, green, blue; tlast: frame end
//  cfg       in    cfg_valid/cfg_ready     cfg_index: register, cfg_data: value
//
// One input transfer is taken in every cycle while the output side keeps up.
// A transfer that completes a result's neighborhood sends that result through
// the read stage, where the line stores are read, and then through the kernel
// adders into the output register. Output back-pressure holds the read stage
// and then the input. Reset clears the counters and pipeline valids and loads
// the default geometry; the line stores hold no reset value and need no clearing pass.
module gaussian_blur_3x3_rgb #(
  parameter int MAX_LINE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input pixel stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gb3_pkg::DATA_W-1:0]      s_axis_tdata,   // in_red, in_green, in_blue
  input  logic                            s_axis_tuser,   // action (1 = flush tick)
  // Result pixel stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gb3_pkg::DATA_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
  output logic                            m_axis_tlast,   // frame_end
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import gb3_pkg::*;

  // Column address width, and a width wide enough to compare any column
  // count against the effective line length.
  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int LW = (AW + 1 > LL_W) ? AW + 1 : LL_W;

  // Kernel row weights 1-2-1, then rows weighted 1-2-1, divided by 16.
  function automatic logic [CH_W-1:0] blur_ch(
    input logic [CH_W-1:0] tl, input logic [CH_W-1:0] tc, input logic [CH_W-1:0] tr,
    input logic [CH_W-1:0] ml, input logic [CH_W-1:0] mc, input logic [CH_W-1:0] mr,
    input logic [CH_W-1:0] bl, input logic [CH_W-1:0] bc, input logic [CH_W-1:0] br
  );
    logic [CH_W+1:0] rt, rm, rb;
    logic [CH_W+3:0] sum;
    rt  = {2'b00, tl} + {1'b0, tc, 1'b0} + {2'b00, tr};
    rm  = {2'b00, ml} + {1'b0, mc, 1'b0} + {2'b00, mr};
    rb  = {2'b00, bl} + {1'b0, bc, 1'b0} + {2'b00, br};
    sum = {2'b00, rt} + {1'b0, rm, 1'b0} + {2'b00, rb};
    return sum[CH_W+3:4];
  endfunction

  // Configuration and position counters.
  logic [LL_W-1:0] ll_q, ll_d;
  logic [LC_W-1:0] lc_q, lc_d;
  logic [LC_W-1:0] in_line_q, in_line_d;
  logic [AW-1:0]   in_pix_q, in_pix_d;
  logic [LC_W-1:0] out_line_q, out_line_d;
  logic [AW-1:0]   out_pix_q, out_pix_d;

  // Read stage: one result whose line store data is being fetched.
  logic            s1_valid_q, s1_valid_d;
  bank_t           s1_bank_q [ROWS];
  logic            s1_use_prev_q;
  logic            s1_last_q;
  logic            s1_byp0_q, s1_byp1_q;
  bank_t           s1_byp_bank_q;
  pixel_t          s1_byp_pix_q;

  // Output register and the center column of the previous result.
  logic            m_valid_q, m_valid_d;
  pixel_t          m_data_q;
  logic            m_last_q;
  pixel_t          prev_q [ROWS];

  logic            accept, pix_write, emit, out_free, cfg_write;
  logic [LW-1:0]   w_eff, in_pix_inc, c_ext, c_inc, nc;
  logic [LC_W-1:0] h_eff, nr, in_line_n;
  logic [AW-1:0]   in_pix_n;
  logic [LC_W:0]   r_inc;
  logic            ready_res, line_wrap, frame_wrap;
  bank_t           row_bank [ROWS];
  pixel_t          in_pix;

  pixel_t          rd0 [BANKS];
  pixel_t          rd1 [BANKS];
  pixel_t          win_l [ROWS];
  pixel_t          win_c [ROWS];
  pixel_t          win_r [ROWS];
  pixel_t          res;

  assign in_pix        = pixel_t'(s_axis_tdata);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_write     = cfg_valid_i && cfg_ready_o;

  // Effective geometry: a zero length or count behaves as one, and a line
  // longer than the store is cut to the store depth.
  always_comb begin
    if (ll_q == '0) begin
      w_eff = LW'(1);
    end else if (LW'(ll_q) > LW'(MAX_LINE)) begin
      w_eff = LW'(MAX_LINE);
    end else begin
      w_eff = LW'(ll_q);
    end
    h_eff = (lc_q == '0) ? LC_W'(1) : lc_q;
  end

  // Input side: a pixel is stored only while the frame still wants pixels.
  // A pixel beyond the end of the frame acts as a flush tick.
  always_comb begin
    pix_write  = accept && !s_axis_tuser && (in_line_q < h_eff);
    in_pix_inc = LW'(in_pix_q) + LW'(1);
    in_pix_n   = in_pix_q;
    in_line_n  = in_line_q;
    if (pix_write) begin
      if (in_pix_inc >= w_eff) begin
        in_pix_n  = '0;
        in_line_n = in_line_q + LC_W'(1);
      end else begin
        in_pix_n  = in_pix_inc[AW-1:0];
      end
    end
  end

  // Output side: the next result is ready once its lower right neighbor,
  // clamped to the frame, has arrived.
  always_comb begin
    c_ext      = LW'(out_pix_q);
    c_inc      = c_ext + LW'(1);
    line_wrap  = (c_inc >= w_eff);
    nc         = line_wrap ? (w_eff - LW'(1)) : c_inc;
    r_inc      = {1'b0, out_line_q} + (LC_W+1)'(1);
    frame_wrap = (r_inc >= {1'b0, h_eff});
    nr         = frame_wrap ? (h_eff - LC_W'(1)) : r_inc[LC_W-1:0];
    ready_res  = (in_line_n > nr) || ((in_line_n == nr) && (LW'(in_pix_n) > nc));
    emit       = accept && ready_res;

    // Store slots of the clamped upper, center and lower rows.
    row_bank[0] = (out_line_q == '0) ? out_line_q[BANK_W-1:0]
                                     : BANK_W'(out_line_q - LC_W'(1));
    row_bank[1] = out_line_q[BANK_W-1:0];
    row_bank[2] = frame_wrap ? out_line_q[BANK_W-1:0] : r_inc[BANK_W-1:0];
  end

  // Next state of the counters and configuration registers.
  always_comb begin
    ll_d       = ll_q;
    lc_d       = lc_q;
    in_pix_d   = in_pix_n;
    in_line_d  = in_line_n;
    out_pix_d  = out_pix_q;
    out_line_d = out_line_q;
    if (emit) begin
      if (line_wrap) begin
        out_pix_d  = '0;
        out_line_d = r_inc[LC_W-1:0];
        if (frame_wrap) begin
          // Last result of the frame: the next frame starts from scratch.
          out_line_d = '0;
          in_pix_d   = '0;
          in_line_d  = '0;
        end
      end else begin
        out_pix_d = c_inc[AW-1:0];
      end
    end
    if (cfg_write) begin
      unique case (cfg_index_i)
        REG_LINE_LENGTH: ll_d = cfg_data_i[LL_W-1:0];
        REG_LINE_COUNT:  lc_d = cfg_data_i[LC_W-1:0];
        default: ;
      endcase
      // A known register write restarts the frame.
      if (cfg_index_i == REG_LINE_LENGTH || cfg_index_i == REG_LINE_COUNT) begin
        in_pix_d   = '0;
        in_line_d  = '0;
        out_pix_d  = '0;
        out_line_d = '0;
      end
    end
  end

  // Four line stores, one per row slot. All of them read the current result
  // column and the clamped column to its right; the row muxes pick the slots.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    gb3_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_LINE)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (pix_write && (in_line_q[BANK_W-1:0] == BANK_W'(b))),
      .waddr_i (in_pix_q),
      .wdata_i (s_axis_tdata),
      .re_i    (accept),
      .raddr0_i(out_pix_q),
      .raddr1_i(nc[AW-1:0]),
      .rdata0_o(rd0[b]),
      .rdata1_o(rd1[b])
    );
  end

  // Window assembly. The pixel written in the same cycle as the read is not
  // yet in the store, so it is forwarded. The left column comes from the
  // previous result of the line, or repeats the center at the left edge.
  always_comb begin
    for (int k = 0; k < ROWS; k++) begin
      win_c[k] = (s1_byp0_q && (s1_byp_bank_q == s1_bank_q[k])) ? s1_byp_pix_q
                                                                 : rd0[s1_bank_q[k]];
      win_r[k] = (s1_byp1_q && (s1_byp_bank_q == s1_bank_q[k])) ? s1_byp_pix_q
                                                                 : rd1[s1_bank_q[k]];
      win_l[k] = s1_use_prev_q ? prev_q[k] : win_c[k];
    end
    res.red   = blur_ch(win_l[0].red,   win_c[0].red,   win_r[0].red,
                        win_l[1].red,   win_c[1].red,   win_r[1].red,
                        win_l[2].red,   win_c[2].red,   win_r[2].red);
    res.green = blur_ch(win_l[0].green, win_c[0].green, win_r[0].green,
                        win_l[1].green, win_c[1].green, win_r[1].green,
                        win_l[2].green, win_c[2].green, win_r[2].green);
    res.blue  = blur_ch(win_l[0].blue,  win_c[0].blue,  win_r[0].blue,
                        win_l[1].blue,  win_c[1].blue,  win_r[1].blue,
                        win_l[2].blue,  win_c[2].blue,  win_r[2].blue);
  end

  // Pipeline valids: every input transfer reloads the read stage, valid only if
  // that transfer sends a result; it empties into the output register whenever that one is free.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = emit;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = out_free ? s1_valid_q : m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ll_q       <= LL_RESET;
      lc_q       <= LC_RESET;
      in_line_q  <= '0;
      in_pix_q   <= '0;
      out_line_q <= '0;
      out_pix_q  <= '0;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      ll_q       <= ll_d;
      lc_q       <= lc_d;
      in_line_q  <= in_line_d;
      in_pix_q   <= in_pix_d;
      out_line_q <= out_line_d;
      out_pix_q  <= out_pix_d;
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int k = 0; k < ROWS; k++) begin
        s1_bank_q[k] <= row_bank[k];
      end
      s1_use_prev_q <= (out_pix_q != '0);
      s1_last_q     <= line_wrap && frame_wrap;
      s1_byp0_q     <= pix_write && (in_pix_q == out_pix_q);
      s1_byp1_q     <= pix_write && (in_pix_q == nc[AW-1:0]);
      s1_byp_bank_q <= in_line_q[BANK_W-1:0];
      s1_byp_pix_q  <= in_pix;
    end
    if (s1_valid_q && out_free) begin
      m_data_q <= res;
      m_last_q <= s1_last_q;
      for (int k = 0; k < ROWS; k++) begin
        prev_q[k] <= win_c[k];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule
